// ----- rtl/free_frame_stack_defines.svh -----
// ----------------------------------------------------------------------------
// Free frame stack assertion macros
// Shared concurrent assertion forms for the free frame stack RTL.
// ----------------------------------------------------------------------------
`ifndef FREE_FRAME_STACK_DEFINES_SVH
`define FREE_FRAME_STACK_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define FFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ffs_pkg.sv -----
// ----------------------------------------------------------------------------
// Free frame stack package
// Types, codes and default sizes shared by the stack cells and the top level.
// ----------------------------------------------------------------------------
package ffs_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int FRAME_BITS_DEF = 20;
    localparam int CAP_BITS       = 11;
    localparam int CAP_RESET      = 1024;
    localparam int COUNT_OUT_BITS = 11;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic push;
        logic pop;
        logic remove;
    } t_cell_ctl;

endpackage

// ----- rtl/free_frame_stack.sv -----
// ----------------------------------------------------------------------------
// Free frame stack
// LIFO allocator of free physical frame numbers built as a chain of cells.
// ----------------------------------------------------------------------------
// In the cycle an item is accepted every cell compares its frame with the
// item's frame, and in the next cycle the whole chain shifts at once (toward
// the bottom on push, toward the top on pop, and on remove the entries deeper
// than the removed one move up one cell) while the result is registered. The
// top of the stack sits in cell 0, so pop reads it directly. A new item is
// not accepted before the previous one has executed, nor while a result is
// held by the output stall; the remove search is a priority ripple through all
// cells in the shift cycle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "free_frame_stack_defines.svh"

module free_frame_stack
    import ffs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CAP_BITS-1:0]       i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic [FRAME_BITS-1:0]     i_frame_number,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [FRAME_BITS-1:0]     o_frame_out,
    output logic [COUNT_OUT_BITS-1:0] o_fill_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                    r_state;
    t_op                       r_op;
    logic [FRAME_BITS-1:0]     r_frame;
    logic [CAP_BITS-1:0]       r_cap;
    logic [CW-1:0]             r_count;
    logic                      r_out_valid;
    t_status                   r_status;
    logic [FRAME_BITS-1:0]     r_frame_out;
    logic [COUNT_OUT_BITS-1:0] r_fill;

    logic [CW-1:0]             n_count;
    t_status                   n_status;
    logic [FRAME_BITS-1:0]     n_frame_out;

    logic                      w_accept;
    logic                      w_exec;
    logic [LW-1:0]             w_limit;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_found;
    t_cell_ctl                 w_ctl;
    logic [FRAME_BITS-1:0]     w_data [DEPTH];
    logic [DEPTH:0]            w_seen;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_exec     = (r_state == S_EXEC);

    assign w_limit = (LW'(r_cap) < LW'(DEPTH)) ? LW'(r_cap) : LW'(DEPTH);
    assign w_full  = LW'(r_count) >= w_limit;
    assign w_empty = (r_count == '0);
    assign w_found = w_seen[0];

    assign w_ctl.capture = w_accept;
    assign w_ctl.push    = w_exec && (r_op == OP_PUSH) && !w_full;
    assign w_ctl.pop     = w_exec && (r_op == OP_POP) && !w_empty;
    assign w_ctl.remove  = w_exec && (r_op == OP_REMOVE) && w_found;

    assign w_seen[DEPTH] = 1'b0;

    genvar c;
    generate
        for (c = 0; c < DEPTH; c++) begin : g_cell
            logic [FRAME_BITS-1:0] w_prev;
            logic [FRAME_BITS-1:0] w_next;

            if (c == 0) begin : g_top
                assign w_prev = r_frame;
            end else begin : g_mid
                assign w_prev = w_data[c-1];
            end
            if (c == DEPTH - 1) begin : g_bottom
                assign w_next = w_data[c];
            end else begin : g_above
                assign w_next = w_data[c+1];
            end

            ffs_cell #(
                .FRAME_BITS(FRAME_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_cmp_frame(i_frame_number),
                .i_prev     (w_prev),
                .i_next     (w_next),
                .i_live     (CW'(c) < r_count),
                .i_seen     (w_seen[c+1]),
                .o_seen     (w_seen[c]),
                .o_data     (w_data[c])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_frame_out = r_frame;
        unique case (r_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count     = r_count - CW'(1);
                    n_frame_out = w_data[0];
                end
            end
            OP_REMOVE: begin
                if (!w_found) begin
                    n_status = ST_MISSING;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_BITS'(CAP_RESET);
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= t_op'(i_op);
                        r_frame <= i_frame_number;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count     <= n_count;
                    r_status    <= n_status;
                    r_frame_out <= n_frame_out;
                    r_fill      <= COUNT_OUT_BITS'(LW'(n_count));
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_frame_out  = r_frame_out;
    assign o_fill_count = r_fill;

    `FFS_ASSERT(a_count_in_range, LW'(r_count) <= LW'(DEPTH), "fill count exceeds depth")
    `FFS_ASSERT_NEXT(a_accept_to_exec, w_accept, r_state == S_EXEC, "accepted item not executed")
    `FFS_ASSERT_NEXT(a_exec_gives_result, w_exec, r_out_valid, "executed item gave no result")
    `FFS_ASSERT_NEXT(a_push_grows, w_ctl.push, r_count == $past(r_count) + CW'(1),
        "successful push did not grow the stack")
    `FFS_ASSERT(a_no_accept_on_stall, (r_out_valid && i_out_stall) |-> !w_accept,
        "item accepted while a result is stalled")

endmodule

// ----- rtl/ffs_cell.sv -----
// ----------------------------------------------------------------------------
// Free frame stack cell
// One stack entry: holds a frame, compares it against an incoming item and
// shifts toward or away from the top as the stack grows, shrinks or closes a gap.
// ----------------------------------------------------------------------------
module ffs_cell
    import ffs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [FRAME_BITS-1:0] i_cmp_frame,
    input  logic [FRAME_BITS-1:0] i_prev,
    input  logic [FRAME_BITS-1:0] i_next,
    input  logic                  i_live,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic [FRAME_BITS-1:0] o_data
);

    logic [FRAME_BITS-1:0] r_data;
    logic                  r_match;

    // A match deeper in the stack wins, so the flag ripples toward the top.
    assign o_seen = i_seen | (r_match & i_live);
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= (r_data == i_cmp_frame);
        end
        if (i_ctl.push) begin
            r_data <= i_prev;
        end else if (i_ctl.pop) begin
            r_data <= i_next;
        end else if (i_ctl.remove && !i_seen) begin
            r_data <= i_next;
        end
    end

endmodule

// ----- sim/free_frame_stack_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free frame stack testbench
// Drives push, pop, remove and no-op items into the stack with random gaps on
// both channels and compares every result with a predictor kept as a queue or,
// for checked rows, with the table. A directed table comes first. Random phases
// then run at several capacities, fill up to a set capacity and end gap-free.
// ----------------------------------------------------------------------------
module free_frame_stack_test;
    import ffs_pkg::*;

    localparam int FB          = FRAME_BITS_DEF;
    localparam int CB          = CAP_BITS;
    localparam int NB          = COUNT_OUT_BITS;
    localparam int WATCHDOG    = 2000;
    localparam int LONG_HOLD   = 240;
    localparam int MAX_REPORTS = 10;
    localparam int FILL_CAP    = 48;

    typedef struct packed {
        t_status       status;
        logic [FB-1:0] frame;
        logic [NB-1:0] count;
    } t_frame_result;

    typedef struct {
        logic          is_cfg;
        logic [CB-1:0] cap;
        t_op           op;
        logic [FB-1:0] frame;
        logic          typed;
        t_frame_result result;
    } t_stim_row;

    logic          i_clk          = 1'b0;
    logic          i_rst_n        = 1'b0;
    logic          i_cfg_we       = 1'b0;
    logic [CB-1:0] i_cfg_data     = '0;
    logic          i_in_valid     = 1'b0;
    logic [1:0]    i_op           = OP_NOP;
    logic [FB-1:0] i_frame_number = '0;
    logic          i_out_stall    = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [1:0]    o_status;
    logic [FB-1:0] o_frame_out;
    logic [NB-1:0] o_fill_count;

    logic [FB-1:0] stack_frames[$];
    logic [CB-1:0] cap_reg;
    t_frame_result pending_results[$];
    t_stim_row     directed_rows[$];
    logic [FB-1:0] frame_pool[16];

    logic gaps_on      = 1'b0;
    logic hold_off_req = 1'b0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   mismatches   = 0;
    int   results_seen = 0;
    int   items_sent   = 0;
    int   op_seen[4]   = '{0, 0, 0, 0};
    int   n_full       = 0;
    int   n_empty      = 0;
    int   n_missing    = 0;
    int   peak_fill    = 0;

    free_frame_stack #(
        .DEPTH      (DEPTH_DEF),
        .FRAME_BITS (FB)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_frame_number (i_frame_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_frame_out    (o_frame_out),
        .o_fill_count   (o_fill_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_frame_result apply_stack_op(t_op op, logic [FB-1:0] frame);
        t_frame_result res;
        int            limit;
        int            hit;
        res.status = ST_OK;
        res.frame  = frame;
        limit      = (cap_reg < DEPTH_DEF) ? int'(cap_reg) : DEPTH_DEF;
        hit        = -1;
        case (op)
            OP_PUSH: begin
                if (stack_frames.size() >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    stack_frames.push_back(frame);
                end
            end
            OP_POP: begin
                if (stack_frames.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.frame = stack_frames.pop_back();
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < stack_frames.size() && hit < 0; i++) begin
                    if (stack_frames[i] == frame) hit = i;
                end
                if (hit < 0) begin
                    res.status = ST_MISSING;
                end else begin
                    stack_frames.delete(hit);
                end
            end
            default: ;
        endcase
        res.count = NB'(stack_frames.size());
        case (res.status)
            ST_FULL:    n_full++;
            ST_EMPTY:   n_empty++;
            ST_MISSING: n_missing++;
            default: ;
        endcase
        if (stack_frames.size() > peak_fill) peak_fill = stack_frames.size();
        return res;
    endfunction

    function automatic logic [FB-1:0] pick_frame();
        if ($urandom_range(0, 1) == 0) return frame_pool[$urandom_range(0, 15)];
        return FB'($urandom_range(0, (1 << FB) - 1));
    endfunction

    task automatic add_row(logic is_cfg, logic [CB-1:0] cap, t_op op, logic [FB-1:0] frame,
                           logic typed, t_status st, logic [FB-1:0] fout, logic [NB-1:0] cnt);
        t_stim_row row;
        row.is_cfg = is_cfg;
        row.cap    = cap;
        row.op     = op;
        row.frame  = frame;
        row.typed  = typed;
        row.result = '{status: st, frame: fout, count: cnt};
        directed_rows.push_back(row);
    endtask

    task automatic send_item(t_op op, logic [FB-1:0] frame, logic typed,
                             t_frame_result typed_result);
        t_frame_result predicted;
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_frame_number <= frame;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = apply_stack_op(op, frame);
        pending_results.push_back(typed ? typed_result : predicted);
        items_sent++;
        op_seen[op]++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CB-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg = value;
    endtask

    task automatic run_random(int n_items, int w_push, int w_pop, int w_rem);
        t_op           op;
        logic [FB-1:0] frame;
        int            r;
        for (int k = 0; k < n_items; k++) begin
            if (gaps_on && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            r = $urandom_range(0, w_push + w_pop + w_rem - 1);
            if ($urandom_range(0, 24) == 0) op = OP_NOP;
            else if (r < w_push) op = OP_PUSH;
            else if (r < w_push + w_pop) op = OP_POP;
            else op = OP_REMOVE;
            frame = pick_frame();
            if (op == OP_REMOVE && stack_frames.size() != 0 && $urandom_range(0, 3) != 0) begin
                frame = stack_frames[$urandom_range(0, stack_frames.size() - 1)];
            end
            send_item(op, frame, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = LONG_HOLD;
        end else if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: status %0d frame %05h count %0d",
                             $time, o_status, o_frame_out, o_fill_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_frame_out !== want.frame ||
                    o_fill_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected status %0d frame %05h count %0d, got %0d %05h %0d",
                                 $time, want.status, want.frame, want.count,
                                 o_status, o_frame_out, o_fill_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                     WATCHDOG, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        cap_reg       = CB'(CAP_RESET);
        frame_pool[0] = '0;
        frame_pool[1] = '1;
        for (int i = 2; i < 16; i++) frame_pool[i] = FB'($urandom_range(0, (1 << FB) - 1));

        //      cfg  cap    op         frame      chk  status      frame_out  count
        add_row(0,   0,     OP_POP,    20'hABCDE, 1,   ST_EMPTY,   20'hABCDE, 0);
        add_row(0,   0,     OP_REMOVE, 20'h12345, 1,   ST_MISSING, 20'h12345, 0);
        add_row(0,   0,     OP_NOP,    20'hFFFFF, 1,   ST_OK,      20'hFFFFF, 0);
        add_row(0,   0,     OP_PUSH,   20'h00000, 1,   ST_OK,      20'h00000, 1);
        add_row(0,   0,     OP_PUSH,   20'hFFFFF, 1,   ST_OK,      20'hFFFFF, 2);
        add_row(0,   0,     OP_POP,    20'h00001, 1,   ST_OK,      20'hFFFFF, 1);
        add_row(0,   0,     OP_POP,    20'h00002, 1,   ST_OK,      20'h00000, 0);
        add_row(0,   0,     OP_POP,    20'h00003, 1,   ST_EMPTY,   20'h00003, 0);
        add_row(0,   0,     OP_PUSH,   20'h55555, 1,   ST_OK,      20'h55555, 1);
        add_row(0,   0,     OP_PUSH,   20'hAAAAA, 1,   ST_OK,      20'hAAAAA, 2);
        add_row(0,   0,     OP_PUSH,   20'h55555, 1,   ST_OK,      20'h55555, 3);
        add_row(0,   0,     OP_PUSH,   20'h00F0F, 1,   ST_OK,      20'h00F0F, 4);
        add_row(0,   0,     OP_REMOVE, 20'h55555, 1,   ST_OK,      20'h55555, 3);
        add_row(0,   0,     OP_REMOVE, 20'h77777, 1,   ST_MISSING, 20'h77777, 3);
        add_row(0,   0,     OP_NOP,    20'h0F0F0, 1,   ST_OK,      20'h0F0F0, 3);
        add_row(0,   0,     OP_POP,    20'h00000, 0,   ST_OK,      20'h00000, 0);
        add_row(0,   0,     OP_POP,    20'h00000, 0,   ST_OK,      20'h00000, 0);
        add_row(0,   0,     OP_POP,    20'h00000, 0,   ST_OK,      20'h00000, 0);
        add_row(1,   0,     OP_NOP,    20'h00000, 0,   ST_OK,      20'h00000, 0);
        add_row(0,   0,     OP_PUSH,   20'h13579, 1,   ST_FULL,    20'h13579, 0);
        add_row(1,   1,     OP_NOP,    20'h00000, 0,   ST_OK,      20'h00000, 0);
        add_row(0,   0,     OP_PUSH,   20'h2468A, 1,   ST_OK,      20'h2468A, 1);
        add_row(0,   0,     OP_PUSH,   20'h11111, 1,   ST_FULL,    20'h11111, 1);
        add_row(0,   0,     OP_POP,    20'h00000, 1,   ST_OK,      20'h2468A, 0);
        add_row(0,   0,     OP_PUSH,   20'h80000, 1,   ST_OK,      20'h80000, 1);
        add_row(0,   0,     OP_REMOVE, 20'h80000, 1,   ST_OK,      20'h80000, 0);
        add_row(1,   2047,  OP_NOP,    20'h00000, 0,   ST_OK,      20'h00000, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_capacity(directed_rows[i].cap);
            end else begin
                send_item(directed_rows[i].op, directed_rows[i].frame,
                          directed_rows[i].typed, directed_rows[i].result);
            end
        end

        gaps_on = 1'b1;
        write_capacity(11'd1024);
        run_random(140, 45, 25, 30);
        write_capacity(11'd8);
        run_random(80, 60, 20, 20);

        write_capacity(CB'(FILL_CAP));
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        while (stack_frames.size() < FILL_CAP) send_item(OP_PUSH, pick_frame(), 1'b0, '0);
        run_random(20, 1, 0, 0);
        gaps_on = 1'b1;
        run_random(60, 30, 30, 40);

        write_capacity(11'd3);
        run_random(50, 40, 30, 30);
        write_capacity(11'd0);
        run_random(25, 50, 25, 25);
        write_capacity(11'd1);
        run_random(25, 40, 30, 30);

        write_capacity(11'd2047);
        run_random(80, 35, 35, 30);
        gaps_on = 1'b0;
        run_random(70, 35, 35, 30);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d items (%0d push, %0d pop, %0d remove, %0d no-op), %0d results.",
                 items_sent, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_REMOVE],
                 op_seen[OP_NOP], results_seen);
        $display("Full %0d, empty %0d, not found %0d, peak fill %0d, mismatches %0d.",
                 n_full, n_empty, n_missing, peak_fill, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- free_frame_stack.f -----
+incdir+rtl
rtl/ffs_pkg.sv
rtl/ffs_cell.sv
rtl/free_frame_stack.sv
sim/free_frame_stack_test.sv
